// ===== src/sct_pkg.sv =====
package sct_pkg;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LT = 8'h3c;
	localparam logic [7:0] CH_GT = 8'h3e;
	localparam logic [7:0] CH_PIPE = 8'h7c;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_WORD = 3'd1,
		MODE_SQ = 3'd2,
		MODE_DQ = 3'd3,
		MODE_LT = 3'd4,
		MODE_GT = 3'd5
	} lex_mode_t;

	typedef enum logic [2:0] {
		T_WORD = 3'd0,
		T_SQ = 3'd1,
		T_DQ = 3'd2,
		T_IN = 3'd3,
		T_OUT = 3'd4,
		T_APPEND = 3'd5,
		T_HEREDOC = 3'd6,
		T_PIPE = 3'd7
	} tok_type_t;

	typedef struct packed {
		logic [2:0] token_type;
		logic has_char;
		logic [7:0] out_char;
		logic token_first;
		logic token_last;
		logic dropped;
		logic line_done;
		logic last_of_run;
	} res_t;

	typedef struct packed {
		logic v0;
		logic v1;
		res_t r0;
		res_t r1;
	} lex_out_t;

	function automatic res_t mk_res(tok_type_t t, logic has, logic [7:0] ch, logic first,
			logic last, logic drop, logic done);
		res_t r;
		r.token_type = t;
		r.has_char = has;
		r.out_char = has ? ch : CH_NUL;
		r.token_first = first;
		r.token_last = last;
		r.dropped = drop;
		r.line_done = done;
		r.last_of_run = 1'b0;
		return r;
	endfunction

endpackage

// ===== src/sct_if.sv =====
interface sct_cmd_if;
	logic valid;
	logic ready;
	logic kind;
	logic [7:0] char_value;

	modport source(output valid, output kind, output char_value, input ready);
	modport sink(input valid, input kind, input char_value, output ready);
endinterface

interface sct_tok_if;
	logic valid;
	logic ready;
	logic [2:0] token_type;
	logic has_char;
	logic [7:0] out_char;
	logic token_first;
	logic token_last;
	logic dropped;
	logic line_done;
	logic last_of_run;

	modport source(output valid, output token_type, output has_char, output out_char,
		output token_first, output token_last, output dropped, output line_done,
		output last_of_run, input ready);
	modport sink(input valid, input token_type, input has_char, input out_char,
		input token_first, input token_last, input dropped, input line_done,
		input last_of_run, output ready);
endinterface

// ===== src/shell_command_tokenizer.sv =====
// Streaming command-line tokenizer.
// The cmd channel takes one line byte per request, or an end-of-line mark
// (kind high, or a zero byte). The tok channel delivers token results: each
// token character with its type and first and last marks, pure markers that
// close words and quoted runs, and an end-of-line report with line_done.
// Each request yields zero, one or two results; last_of_run marks the final one.
// A request is decoded in the cycle it is accepted and its results are
// written into a four-entry result queue, whose head is offered on tok.
// One request is accepted per cycle while each yields at most one result and
// the receiver keeps up; a request that yields two results (a doubled < or >,
// or a byte that closes a word or a pending operator and opens a new token)
// puts both into the queue. The queue absorbs short bursts of these, and a
// long run of them slows cmd to the pace at which tok takes their results.
// When the receiver stalls, results stay in the queue and cmd.ready drops
// once fewer than two entries are free.
// Reset clears the queue and returns the lexer to the state between tokens.
module shell_command_tokenizer (
	input logic clk,
	input logic arst_n,
	sct_cmd_if.sink cmd,
	sct_tok_if.source tok
);

	sct_pkg::lex_out_t lex;
	sct_pkg::res_t head;
	logic [sct_pkg::CNT_W-1:0] count;
	logic accept;
	logic pop;

	assign cmd.ready = (count <= sct_pkg::CNT_W'(sct_pkg::FIFO_DEPTH - 2));
	assign accept = cmd.valid && cmd.ready;
	assign tok.valid = (count != '0);
	assign pop = tok.valid && tok.ready;

	sct_lexer u_lexer (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.kind(cmd.kind),
		.char_value(cmd.char_value),
		.lex(lex)
	);

	sct_result_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.lex(lex),
		.pop(pop),
		.head(head),
		.count(count)
	);

	assign tok.token_type = head.token_type;
	assign tok.has_char = head.has_char;
	assign tok.out_char = head.out_char;
	assign tok.token_first = head.token_first;
	assign tok.token_last = head.token_last;
	assign tok.dropped = head.dropped;
	assign tok.line_done = head.line_done;
	assign tok.last_of_run = head.last_of_run;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= sct_pkg::CNT_W'(sct_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		tok.valid && tok.line_done |-> tok.last_of_run)
		else $error("line_done result is not the last of its request");

	a_marker_char: assert property (@(posedge clk) disable iff (!arst_n)
		tok.valid && !tok.has_char |-> tok.out_char == 8'h00)
		else $error("pure marker carries a character");

	a_second_result: assert property (@(posedge clk) disable iff (!arst_n)
		lex.v1 |-> lex.v0 && !lex.r0.last_of_run)
		else $error("second result without a leading one");

endmodule

// ===== src/sct_lexer.sv =====
module sct_lexer (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic kind,
	input  logic [7:0] char_value,
	output sct_pkg::lex_out_t lex
);

	sct_pkg::lex_mode_t mode_q;
	sct_pkg::lex_mode_t nxt_mode;
	logic open_q;
	logic nxt_open;

	sct_pkg::lex_mode_t i_mode;
	logic i_v;
	sct_pkg::res_t i_r;

	logic eol;
	logic delim;
	logic v0;
	logic v1;
	sct_pkg::res_t r0;
	sct_pkg::res_t r1;

	assign eol = kind || (char_value == sct_pkg::CH_NUL);
	assign delim = (char_value == sct_pkg::CH_SPACE) || (char_value == sct_pkg::CH_TAB)
		|| (char_value == sct_pkg::CH_SQUOTE) || (char_value == sct_pkg::CH_DQUOTE)
		|| (char_value == sct_pkg::CH_LT) || (char_value == sct_pkg::CH_GT)
		|| (char_value == sct_pkg::CH_PIPE);

	// Treatment of a byte as if no token were open.
	always_comb begin
		i_mode = sct_pkg::MODE_IDLE;
		i_v = 1'b0;
		i_r = '0;
		if (char_value == sct_pkg::CH_SPACE || char_value == sct_pkg::CH_TAB) begin
			i_mode = sct_pkg::MODE_IDLE;
		end else if (char_value == sct_pkg::CH_SQUOTE) begin
			i_mode = sct_pkg::MODE_SQ;
		end else if (char_value == sct_pkg::CH_DQUOTE) begin
			i_mode = sct_pkg::MODE_DQ;
		end else if (char_value == sct_pkg::CH_LT) begin
			i_mode = sct_pkg::MODE_LT;
		end else if (char_value == sct_pkg::CH_GT) begin
			i_mode = sct_pkg::MODE_GT;
		end else if (char_value == sct_pkg::CH_PIPE) begin
			i_v = 1'b1;
			i_r = sct_pkg::mk_res(sct_pkg::T_PIPE, 1'b1, char_value, 1'b1, 1'b1, 1'b0, 1'b0);
		end else begin
			i_mode = sct_pkg::MODE_WORD;
			i_v = 1'b1;
			i_r = sct_pkg::mk_res(sct_pkg::T_WORD, 1'b1, char_value, 1'b1, 1'b0, 1'b0, 1'b0);
		end
	end

	always_comb begin
		nxt_mode = mode_q;
		nxt_open = open_q;
		v0 = 1'b0;
		v1 = 1'b0;
		r0 = '0;
		r1 = '0;
		if (eol) begin
			v0 = 1'b1;
			nxt_mode = sct_pkg::MODE_IDLE;
			nxt_open = 1'b0;
			unique case (mode_q)
				sct_pkg::MODE_WORD: r0 = sct_pkg::mk_res(sct_pkg::T_WORD, 1'b0, sct_pkg::CH_NUL,
					1'b0, 1'b1, 1'b0, 1'b1);
				sct_pkg::MODE_SQ: r0 = sct_pkg::mk_res(sct_pkg::T_SQ, 1'b0, sct_pkg::CH_NUL,
					1'b0, open_q, open_q, 1'b1);
				sct_pkg::MODE_DQ: r0 = open_q
					? sct_pkg::mk_res(sct_pkg::T_DQ, 1'b0, sct_pkg::CH_NUL, 1'b0, 1'b1, 1'b1, 1'b1)
					: sct_pkg::mk_res(sct_pkg::T_WORD, 1'b0, sct_pkg::CH_NUL, 1'b0, 1'b0, 1'b0, 1'b1);
				sct_pkg::MODE_LT: r0 = sct_pkg::mk_res(sct_pkg::T_IN, 1'b1, sct_pkg::CH_LT,
					1'b1, 1'b1, 1'b0, 1'b1);
				sct_pkg::MODE_GT: r0 = sct_pkg::mk_res(sct_pkg::T_OUT, 1'b1, sct_pkg::CH_GT,
					1'b1, 1'b1, 1'b0, 1'b1);
				default: r0 = sct_pkg::mk_res(sct_pkg::T_WORD, 1'b0, sct_pkg::CH_NUL,
					1'b0, 1'b0, 1'b0, 1'b1);
			endcase
			// An empty single-quoted run reports as a plain end-of-line marker.
			if (mode_q == sct_pkg::MODE_SQ && !open_q) begin
				r0.token_type = sct_pkg::T_WORD;
			end
		end else begin
			unique case (mode_q)
				sct_pkg::MODE_WORD: begin
					v0 = 1'b1;
					if (delim) begin
						r0 = sct_pkg::mk_res(sct_pkg::T_WORD, 1'b0, sct_pkg::CH_NUL,
							1'b0, 1'b1, 1'b0, 1'b0);
						v1 = i_v;
						r1 = i_r;
						nxt_mode = i_mode;
						nxt_open = (i_mode == sct_pkg::MODE_WORD);
					end else begin
						r0 = sct_pkg::mk_res(sct_pkg::T_WORD, 1'b1, char_value,
							1'b0, 1'b0, 1'b0, 1'b0);
					end
				end
				sct_pkg::MODE_SQ, sct_pkg::MODE_DQ: begin
					v0 = 1'b1;
					if ((mode_q == sct_pkg::MODE_SQ && char_value == sct_pkg::CH_SQUOTE)
							|| (mode_q == sct_pkg::MODE_DQ && char_value == sct_pkg::CH_DQUOTE))
					begin
						r0 = sct_pkg::mk_res((mode_q == sct_pkg::MODE_SQ) ? sct_pkg::T_SQ
							: sct_pkg::T_DQ, 1'b0, sct_pkg::CH_NUL, !open_q, 1'b1, 1'b0, 1'b0);
						nxt_mode = sct_pkg::MODE_IDLE;
						nxt_open = 1'b0;
					end else begin
						r0 = sct_pkg::mk_res((mode_q == sct_pkg::MODE_SQ) ? sct_pkg::T_SQ
							: sct_pkg::T_DQ, 1'b1, char_value, !open_q, 1'b0, 1'b0, 1'b0);
						nxt_open = 1'b1;
					end
				end
				sct_pkg::MODE_LT, sct_pkg::MODE_GT: begin
					v0 = 1'b1;
					if ((mode_q == sct_pkg::MODE_LT && char_value == sct_pkg::CH_LT)
							|| (mode_q == sct_pkg::MODE_GT && char_value == sct_pkg::CH_GT))
					begin
						r0 = sct_pkg::mk_res((mode_q == sct_pkg::MODE_LT) ? sct_pkg::T_HEREDOC
							: sct_pkg::T_APPEND, 1'b1, char_value, 1'b1, 1'b0, 1'b0, 1'b0);
						r1 = sct_pkg::mk_res((mode_q == sct_pkg::MODE_LT) ? sct_pkg::T_HEREDOC
							: sct_pkg::T_APPEND, 1'b1, char_value, 1'b0, 1'b1, 1'b0, 1'b0);
						v1 = 1'b1;
						nxt_mode = sct_pkg::MODE_IDLE;
						nxt_open = 1'b0;
					end else begin
						r0 = (mode_q == sct_pkg::MODE_LT)
							? sct_pkg::mk_res(sct_pkg::T_IN, 1'b1, sct_pkg::CH_LT,
								1'b1, 1'b1, 1'b0, 1'b0)
							: sct_pkg::mk_res(sct_pkg::T_OUT, 1'b1, sct_pkg::CH_GT,
								1'b1, 1'b1, 1'b0, 1'b0);
						v1 = i_v;
						r1 = i_r;
						nxt_mode = i_mode;
						nxt_open = (i_mode == sct_pkg::MODE_WORD);
					end
				end
				default: begin
					v0 = i_v;
					r0 = i_r;
					nxt_mode = i_mode;
					nxt_open = (i_mode == sct_pkg::MODE_WORD);
				end
			endcase
		end
		if (v1) begin
			r1.last_of_run = 1'b1;
		end else begin
			r0.last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sct_pkg::MODE_IDLE;
			open_q <= 1'b0;
		end else if (accept) begin
			mode_q <= nxt_mode;
			open_q <= nxt_open;
		end
	end

	assign lex.v0 = accept && v0;
	assign lex.v1 = accept && v1;
	assign lex.r0 = r0;
	assign lex.r1 = r1;

endmodule

// ===== src/sct_result_fifo.sv =====
module sct_result_fifo (
	input  logic clk,
	input  logic arst_n,
	input  sct_pkg::lex_out_t lex,
	input  logic pop,
	output sct_pkg::res_t head,
	output logic [sct_pkg::CNT_W-1:0] count
);

	sct_pkg::res_t mem_q [sct_pkg::FIFO_DEPTH];
	logic [sct_pkg::PTR_W-1:0] wr_ptr_q;
	logic [sct_pkg::PTR_W-1:0] rd_ptr_q;
	logic [sct_pkg::CNT_W-1:0] count_q;
	logic [1:0] n_push;

	assign n_push = {1'b0, lex.v0} + {1'b0, lex.v1};

	always_ff @(posedge clk) begin
		if (lex.v0) begin
			mem_q[wr_ptr_q] <= lex.r0;
		end
		if (lex.v1) begin
			mem_q[wr_ptr_q + sct_pkg::PTR_W'(1)] <= lex.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + sct_pkg::PTR_W'(n_push);
			rd_ptr_q <= rd_ptr_q + sct_pkg::PTR_W'(pop);
			count_q <= count_q + sct_pkg::CNT_W'(n_push) - sct_pkg::CNT_W'(pop);
		end
	end

	assign head = mem_q[rd_ptr_q];
	assign count = count_q;

endmodule

// ===== test/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_EOL = 1'b1;
	localparam int RANDOM_ITEMS = 450;
	localparam int HOLD_CYCLES = 60;
	localparam int IDLE_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 10;

	class token_scoreboard;
		sct_pkg::lex_mode_t mode = sct_pkg::MODE_IDLE;
		bit tok_open = 1'b0;
		sct_pkg::res_t expected_tokens[$];
		int n_err = 0;
		int n_checked = 0;

		function int pending();
			return expected_tokens.size();
		endfunction

		function void add_res(sct_pkg::tok_type_t t, bit has, logic [7:0] ch, bit first,
				bit last, bit drop, bit done);
			sct_pkg::res_t r;
			r.token_type = t;
			r.has_char = has;
			r.out_char = has ? ch : sct_pkg::CH_NUL;
			r.token_first = first;
			r.token_last = last;
			r.dropped = drop;
			r.line_done = done;
			r.last_of_run = 1'b0;
			expected_tokens.push_back(r);
		endfunction

		function bit is_delim(logic [7:0] ch);
			return ch == sct_pkg::CH_SPACE || ch == sct_pkg::CH_TAB
				|| ch == sct_pkg::CH_SQUOTE || ch == sct_pkg::CH_DQUOTE
				|| ch == sct_pkg::CH_LT || ch == sct_pkg::CH_GT || ch == sct_pkg::CH_PIPE;
		endfunction

		function void open_token(logic [7:0] ch);
			tok_open = 1'b0;
			if (ch == sct_pkg::CH_SPACE || ch == sct_pkg::CH_TAB) begin
				mode = sct_pkg::MODE_IDLE;
			end else if (ch == sct_pkg::CH_SQUOTE) begin
				mode = sct_pkg::MODE_SQ;
			end else if (ch == sct_pkg::CH_DQUOTE) begin
				mode = sct_pkg::MODE_DQ;
			end else if (ch == sct_pkg::CH_LT) begin
				mode = sct_pkg::MODE_LT;
			end else if (ch == sct_pkg::CH_GT) begin
				mode = sct_pkg::MODE_GT;
			end else if (ch == sct_pkg::CH_PIPE) begin
				mode = sct_pkg::MODE_IDLE;
				add_res(sct_pkg::T_PIPE, 1'b1, ch, 1'b1, 1'b1, 1'b0, 1'b0);
			end else begin
				mode = sct_pkg::MODE_WORD;
				tok_open = 1'b1;
				add_res(sct_pkg::T_WORD, 1'b1, ch, 1'b1, 1'b0, 1'b0, 1'b0);
			end
		endfunction

		function void note_request(logic kind, logic [7:0] ch);
			int base;
			bit eol;
			bit is_lt;
			sct_pkg::tok_type_t t;
			logic [7:0] mark;
			base = expected_tokens.size();
			eol = kind == KIND_EOL || ch == sct_pkg::CH_NUL;
			is_lt = mode == sct_pkg::MODE_LT;
			if (eol) begin
				if (mode == sct_pkg::MODE_WORD) begin
					add_res(sct_pkg::T_WORD, 1'b0, sct_pkg::CH_NUL, 1'b0, 1'b1, 1'b0, 1'b1);
				end else if ((mode == sct_pkg::MODE_SQ || mode == sct_pkg::MODE_DQ)
						&& tok_open) begin
					t = (mode == sct_pkg::MODE_SQ) ? sct_pkg::T_SQ : sct_pkg::T_DQ;
					add_res(t, 1'b0, sct_pkg::CH_NUL, 1'b0, 1'b1, 1'b1, 1'b1);
				end else if (mode == sct_pkg::MODE_LT || mode == sct_pkg::MODE_GT) begin
					t = is_lt ? sct_pkg::T_IN : sct_pkg::T_OUT;
					mark = is_lt ? sct_pkg::CH_LT : sct_pkg::CH_GT;
					add_res(t, 1'b1, mark, 1'b1, 1'b1, 1'b0, 1'b1);
				end else begin
					add_res(sct_pkg::T_WORD, 1'b0, sct_pkg::CH_NUL, 1'b0, 1'b0, 1'b0, 1'b1);
				end
				mode = sct_pkg::MODE_IDLE;
				tok_open = 1'b0;
			end else if (mode == sct_pkg::MODE_WORD) begin
				if (is_delim(ch)) begin
					add_res(sct_pkg::T_WORD, 1'b0, sct_pkg::CH_NUL, 1'b0, 1'b1, 1'b0, 1'b0);
					open_token(ch);
				end else begin
					add_res(sct_pkg::T_WORD, 1'b1, ch, 1'b0, 1'b0, 1'b0, 1'b0);
				end
			end else if (mode == sct_pkg::MODE_SQ || mode == sct_pkg::MODE_DQ) begin
				t = (mode == sct_pkg::MODE_SQ) ? sct_pkg::T_SQ : sct_pkg::T_DQ;
				mark = (mode == sct_pkg::MODE_SQ) ? sct_pkg::CH_SQUOTE : sct_pkg::CH_DQUOTE;
				if (ch == mark) begin
					add_res(t, 1'b0, sct_pkg::CH_NUL, !tok_open, 1'b1, 1'b0, 1'b0);
					mode = sct_pkg::MODE_IDLE;
					tok_open = 1'b0;
				end else begin
					add_res(t, 1'b1, ch, !tok_open, 1'b0, 1'b0, 1'b0);
					tok_open = 1'b1;
				end
			end else if (mode == sct_pkg::MODE_LT || mode == sct_pkg::MODE_GT) begin
				mark = is_lt ? sct_pkg::CH_LT : sct_pkg::CH_GT;
				if (ch == mark) begin
					t = is_lt ? sct_pkg::T_HEREDOC : sct_pkg::T_APPEND;
					add_res(t, 1'b1, mark, 1'b1, 1'b0, 1'b0, 1'b0);
					add_res(t, 1'b1, mark, 1'b0, 1'b1, 1'b0, 1'b0);
					mode = sct_pkg::MODE_IDLE;
					tok_open = 1'b0;
				end else begin
					t = is_lt ? sct_pkg::T_IN : sct_pkg::T_OUT;
					add_res(t, 1'b1, mark, 1'b1, 1'b1, 1'b0, 1'b0);
					open_token(ch);
				end
			end else begin
				open_token(ch);
			end
			if (expected_tokens.size() > base)
				expected_tokens[expected_tokens.size() - 1].last_of_run = 1'b1;
		endfunction

		task report(string what, logic [7:0] got, logic [7:0] want);
			$display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
			n_err++;
		endtask

		task check_token(sct_pkg::res_t got);
			sct_pkg::res_t want;
			if (expected_tokens.size() == 0) begin
				report("unexpected result", got.out_char, sct_pkg::CH_NUL);
			end else begin
				want = expected_tokens.pop_front();
				n_checked++;
				if (got.token_type !== want.token_type)
					report("token_type", 8'(got.token_type), 8'(want.token_type));
				if (got.has_char !== want.has_char)
					report("has_char", 8'(got.has_char), 8'(want.has_char));
				if (got.out_char !== want.out_char)
					report("out_char", got.out_char, want.out_char);
				if (got.token_first !== want.token_first)
					report("token_first", 8'(got.token_first), 8'(want.token_first));
				if (got.token_last !== want.token_last)
					report("token_last", 8'(got.token_last), 8'(want.token_last));
				if (got.dropped !== want.dropped)
					report("dropped", 8'(got.dropped), 8'(want.dropped));
				if (got.line_done !== want.line_done)
					report("line_done", 8'(got.line_done), 8'(want.line_done));
				if (got.last_of_run !== want.last_of_run)
					report("last_of_run", 8'(got.last_of_run), 8'(want.last_of_run));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	sct_cmd_if cmd_bus();
	sct_tok_if tok_bus();

	shell_command_tokenizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.tok(tok_bus)
	);

	token_scoreboard sb = new;

	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	bit hold_req = 1'b0;
	int n_req = 0;
	int n_lines = 0;
	int n_drains = 0;

	logic [8:0] opening_items [30] = '{
		{KIND_CHAR, 8'hFF}, {KIND_CHAR, 8'h01}, {KIND_CHAR, sct_pkg::CH_SQUOTE},
		{KIND_CHAR, 8'h7F}, {KIND_CHAR, sct_pkg::CH_SQUOTE}, {KIND_CHAR, sct_pkg::CH_SQUOTE},
		{KIND_CHAR, sct_pkg::CH_SQUOTE}, {KIND_CHAR, sct_pkg::CH_DQUOTE},
		{KIND_CHAR, sct_pkg::CH_DQUOTE}, {KIND_CHAR, sct_pkg::CH_DQUOTE},
		{KIND_CHAR, 8'h80}, {KIND_EOL, 8'hA5},
		{KIND_CHAR, sct_pkg::CH_LT}, {KIND_CHAR, sct_pkg::CH_LT},
		{KIND_CHAR, sct_pkg::CH_GT}, {KIND_CHAR, sct_pkg::CH_GT},
		{KIND_CHAR, sct_pkg::CH_LT}, {KIND_CHAR, 8'h78}, {KIND_CHAR, sct_pkg::CH_TAB},
		{KIND_CHAR, 8'h6B}, {KIND_CHAR, sct_pkg::CH_PIPE},
		{KIND_CHAR, sct_pkg::CH_GT}, {KIND_CHAR, sct_pkg::CH_SPACE}, {KIND_CHAR, 8'h77},
		{KIND_CHAR, sct_pkg::CH_NUL},
		{KIND_CHAR, sct_pkg::CH_SQUOTE}, {KIND_EOL, 8'h00}, {KIND_EOL, 8'h5A},
		{KIND_CHAR, sct_pkg::CH_LT}, {KIND_EOL, 8'hFF}
	};

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 38)
			return 8'($urandom_range(1, 255));
		if (r < 46)
			return sct_pkg::CH_SPACE;
		if (r < 50)
			return sct_pkg::CH_TAB;
		if (r < 60)
			return sct_pkg::CH_SQUOTE;
		if (r < 68)
			return sct_pkg::CH_DQUOTE;
		if (r < 76)
			return sct_pkg::CH_LT;
		if (r < 84)
			return sct_pkg::CH_GT;
		if (r < 90)
			return sct_pkg::CH_PIPE;
		if (r < 92)
			return sct_pkg::CH_NUL;
		return 8'($urandom_range(8'h61, 8'h7A));
	endfunction

	task automatic send_req(input logic kind, input logic [7:0] ch);
		int gap;
		gap = tx_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.kind <= kind;
		cmd_bus.char_value <= ch;
		do @(posedge clk); while (!cmd_bus.ready);
		sb.note_request(kind, ch);
		n_req++;
	endtask

	task automatic wait_for_results();
		cmd_bus.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		n_drains++;
	endtask

	initial begin
		int line_len;
		logic [7:0] eol_char;
		arst_n <= 1'b0;
		cmd_bus.valid <= 1'b0;
		cmd_bus.kind <= KIND_CHAR;
		cmd_bus.char_value <= sct_pkg::CH_NUL;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (opening_items[i])
			send_req(opening_items[i][8], opening_items[i][7:0]);
		wait_for_results();

		while (n_req < RANDOM_ITEMS) begin
			tx_quiet = n_lines >= 20 && n_lines < 30;
			rx_quiet = tx_quiet;
			if ($urandom_range(0, 9) == 0)
				line_len = $urandom_range(15, 30);
			else
				line_len = $urandom_range(0, 10);
			// Stall the output for a long stretch while requests keep coming back to back.
			if (n_lines == 6) begin
				hold_req = 1'b1;
				tx_quiet = 1'b1;
				line_len = 24;
			end
			for (int i = 0; i < line_len; i++)
				send_req(KIND_CHAR, pick_byte());
			if ($urandom_range(0, 9) != 0) begin
				eol_char = 8'($urandom_range(0, 255));
				send_req(KIND_EOL, eol_char);
			end
			n_lines++;
			if (n_lines % 15 == 0)
				wait_for_results();
		end
		cmd_bus.valid <= 1'b0;
		rx_quiet = 1'b1;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d requests over %0d lines; %0d results checked, %0d mismatches.",
			n_req, n_lines, sb.n_checked, sb.n_err);
		$display("The run included one long output hold-off and %0d full drains.", n_drains);
		if (sb.n_err == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		int hold_left;
		int stall_left;
		sct_pkg::res_t got;
		hold_left = 0;
		stall_left = 0;
		tok_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && tok_bus.valid && tok_bus.ready) begin
				got = {tok_bus.token_type, tok_bus.has_char, tok_bus.out_char,
					tok_bus.token_first, tok_bus.token_last, tok_bus.dropped,
					tok_bus.line_done, tok_bus.last_of_run};
				sb.check_token(got);
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				tok_bus.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				tok_bus.ready <= 1'b0;
			end else begin
				tok_bus.ready <= 1'b1;
				if (!rx_quiet && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cmd_bus.valid && cmd_bus.ready) || (tok_bus.valid && tok_bus.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("No handshake on either channel for %0d cycles.", IDLE_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

endmodule
